>>> src/iale_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iale_pkg
// Shared constants, command codes and chain control type for the indexed
// array list engine.
// ----------------------------------------------------------------------------
package iale_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int ELEM_WIDTH_DEF = 32;

    // Port field widths
    localparam int CMD_W  = 3;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int FIDX_W = 8;
    localparam int CNT_W  = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRED   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd6;

    // Source of the word fed into the tail of the ring
    typedef logic [1:0] inj_sel_t;
    localparam inj_sel_t INJ_HEAD  = 2'd0;
    localparam inj_sel_t INJ_NEXT  = 2'd1;
    localparam inj_sel_t INJ_KEY   = 2'd2;
    localparam inj_sel_t INJ_CARRY = 2'd3;

    typedef struct packed {
        logic     shift;
        inj_sel_t inj_sel;
    } chain_ctrl_t;

endpackage

>>> src/iale_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iale_cell
// One storage cell of the ring; loads its neighbor's word on shift.
// ----------------------------------------------------------------------------
module iale_cell #(
    parameter int ELEM_WIDTH = iale_pkg::ELEM_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  shift,
    input  logic [ELEM_WIDTH-1:0] d,
    output logic [ELEM_WIDTH-1:0] q
);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    assign data_next = shift ? d : data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

>>> src/iale_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iale_ctrl
// Command sequencer: steps the ring one word per cycle, does the compares
// and builds the result word.
// ----------------------------------------------------------------------------
module iale_ctrl #(
    parameter int CAPACITY   = iale_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = iale_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [iale_pkg::CMD_W-1:0]           cmd,
    input  logic [iale_pkg::POS_W-1:0]           position,
    input  logic signed [iale_pkg::VAL_W-1:0]    value_in,
    input  logic [ELEM_WIDTH-1:0]                head,
    input  logic [ELEM_WIDTH-1:0]                second,
    output iale_pkg::chain_ctrl_t                chain_ctrl,
    output logic [ELEM_WIDTH-1:0]                key,
    output logic                                 busy,
    output logic                                 done,
    output logic                                 status,
    output logic signed [iale_pkg::VAL_W-1:0]    value_out,
    output logic [iale_pkg::FIDX_W-1:0]          found_index,
    output logic [iale_pkg::CNT_W-1:0]           count,
    output logic                                 is_empty
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = (LEN_W > iale_pkg::POS_W) ? LEN_W + 1 : iale_pkg::POS_W + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                           state_reg, state_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [iale_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [iale_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [ELEM_WIDTH-1:0]          key_reg, key_next;
    logic                           ok_reg, ok_next;
    logic                           found_reg, found_next;
    logic [ELEM_WIDTH-1:0]          prev_reg, prev_next;
    logic [ELEM_WIDTH-1:0]          res_reg, res_next;
    logic [iale_pkg::FIDX_W-1:0]    fidx_reg, fidx_next;
    logic                           done_reg, done_next;
    logic                           status_reg, status_next;

    logic          accept;
    logic          last;
    logic          match;
    logic [CW-1:0] idx_cw, pos_cw, len_cw, in_pos_cw;
    logic          ins_ok, idx_ok;

    assign accept    = start && (state_reg == S_IDLE);
    assign last      = (idx_reg == IDX_W'(CAPACITY - 1));
    assign match     = (head == key_reg);
    assign idx_cw    = CW'(idx_reg);
    assign pos_cw    = CW'(pos_reg);
    assign len_cw    = CW'(len_reg);
    assign in_pos_cw = CW'(position);
    assign ins_ok    = (in_pos_cw <= len_cw) && (len_reg != LEN_W'(CAPACITY));
    assign idx_ok    = (in_pos_cw < len_cw);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        ok_next     = ok_reg;
        found_next  = found_reg;
        prev_next   = prev_reg;
        res_next    = res_reg;
        fidx_next   = fidx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        chain_ctrl.shift   = 1'b0;
        chain_ctrl.inj_sel = iale_pkg::INJ_HEAD;

        if (state_reg == S_IDLE)
        begin
            if (accept)
            begin
                cmd_next   = cmd;
                pos_next   = position;
                key_next   = ELEM_WIDTH'(value_in);
                found_next = 1'b0;
                res_next   = '0;
                fidx_next  = '0;
                idx_next   = '0;
                case (cmd)
                    iale_pkg::CMD_CLEAR:
                    begin
                        len_next    = '0;
                        status_next = 1'b0;
                        done_next   = 1'b1;
                    end
                    iale_pkg::CMD_INSERT:
                    begin
                        ok_next    = ins_ok;
                        state_next = S_WALK;
                    end
                    iale_pkg::CMD_DELETE,
                    iale_pkg::CMD_GET:
                    begin
                        ok_next    = idx_ok;
                        state_next = S_WALK;
                    end
                    iale_pkg::CMD_LOCATE,
                    iale_pkg::CMD_PRED,
                    iale_pkg::CMD_SUCC:
                    begin
                        ok_next    = 1'b0;
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        status_next = 1'b1;
                        done_next   = 1'b1;
                    end
                endcase
            end
        end
        else
        begin
            // one ring rotation step; head holds entry idx_reg
            chain_ctrl.shift = 1'b1;
            prev_next        = head;
            case (cmd_reg)
                iale_pkg::CMD_INSERT:
                begin
                    if (ok_reg)
                    begin
                        if (idx_cw < pos_cw)
                            chain_ctrl.inj_sel = iale_pkg::INJ_HEAD;
                        else if (idx_cw == pos_cw)
                            chain_ctrl.inj_sel = iale_pkg::INJ_KEY;
                        else
                            chain_ctrl.inj_sel = iale_pkg::INJ_CARRY;
                    end
                end
                iale_pkg::CMD_DELETE:
                begin
                    if (ok_reg && (idx_cw >= pos_cw))
                        chain_ctrl.inj_sel = iale_pkg::INJ_NEXT;
                    if (ok_reg && (idx_cw == pos_cw))
                        res_next = head;
                end
                iale_pkg::CMD_GET:
                begin
                    if (ok_reg && (idx_cw == pos_cw))
                        res_next = head;
                end
                iale_pkg::CMD_LOCATE:
                begin
                    if (!found_reg && match && (idx_cw < len_cw))
                    begin
                        found_next = 1'b1;
                        fidx_next  = iale_pkg::FIDX_W'(idx_reg);
                    end
                end
                iale_pkg::CMD_PRED:
                begin
                    if (!found_reg && match && (idx_reg != '0) && (idx_cw < len_cw))
                    begin
                        found_next = 1'b1;
                        res_next   = prev_reg;
                    end
                end
                iale_pkg::CMD_SUCC:
                begin
                    if (!found_reg && match && ((idx_cw + CW'(1)) < len_cw))
                    begin
                        found_next = 1'b1;
                        res_next   = second;
                    end
                end
                default:
                begin
                end
            endcase

            idx_next = idx_reg + IDX_W'(1);
            if (last)
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    iale_pkg::CMD_INSERT:
                    begin
                        status_next = !ok_reg;
                        if (ok_reg)
                            len_next = len_reg + LEN_W'(1);
                    end
                    iale_pkg::CMD_DELETE:
                    begin
                        status_next = !ok_reg;
                        if (ok_reg)
                            len_next = len_reg - LEN_W'(1);
                    end
                    iale_pkg::CMD_GET:
                        status_next = !ok_reg;
                    default:
                        status_next = !found_next;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        ok_reg     <= ok_next;
        found_reg  <= found_next;
        prev_reg   <= prev_next;
        res_reg    <= res_next;
        fidx_reg   <= fidx_next;
        status_reg <= status_next;
    end

    assign key         = key_reg;
    assign busy        = (state_reg == S_WALK);
    assign done        = done_reg;
    assign status      = status_reg;
    assign value_out   = iale_pkg::VAL_W'(signed'(res_reg));
    assign found_index = fidx_reg;
    assign count       = iale_pkg::CNT_W'(len_reg);
    assign is_empty    = (len_reg == '0);

endmodule

>>> src/indexed_array_list_engine.sv
`timescale 1ns / 1ps
// Insert, delete, get, locate, predecessor and successor walk the ring through
//   every cell in turn; the result strobes once the walk has ended.
// Clear and the unused code report in the cycle right after start.
// A new command is taken only once the walk has finished, since the ring
//   passes every cell past the head once per command.
// Reset: list length goes to zero; cell contents stay undefined until written.
// ----------------------------------------------------------------------------
// indexed_array_list_engine
// Fixed-capacity ordered list of signed words held in a rotating ring of cells.
// ----------------------------------------------------------------------------
module indexed_array_list_engine #(
    parameter int CAPACITY   = iale_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = iale_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [iale_pkg::CMD_W-1:0]        cmd,
    input  logic [iale_pkg::POS_W-1:0]        position,
    input  logic signed [iale_pkg::VAL_W-1:0] value_in,
    output logic                              busy,
    output logic                              done,
    output logic                              status,
    output logic signed [iale_pkg::VAL_W-1:0] value_out,
    output logic [iale_pkg::FIDX_W-1:0]       found_index,
    output logic [iale_pkg::CNT_W-1:0]        count,
    output logic                              is_empty
);

    // Ring of cells: cell k holds list entry k when idle. During a command
    // every cell loads its upper neighbor each cycle, so entry i sits in the
    // head cell at step i, and the tail cell is fed the rebuilt sequence.
    // After CAPACITY steps the ring is back in order, with the edit applied.
    logic [ELEM_WIDTH-1:0] cell_q [CAPACITY];
    logic [ELEM_WIDTH-1:0] inject;
    logic [ELEM_WIDTH-1:0] key;
    iale_pkg::chain_ctrl_t chain_ctrl;

    // Carry holds the previous head word; an insert feeds it in after the
    // new word so later entries slide up by one.
    logic [ELEM_WIDTH-1:0] carry_reg;
    logic [ELEM_WIDTH-1:0] carry_next;

    assign carry_next = chain_ctrl.shift ? cell_q[0] : carry_reg;

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    // Tail feed: head recirculates, next skips the deleted entry, key is the
    // inserted word, carry is the delayed head.
    always_comb
    begin
        case (chain_ctrl.inj_sel)
            iale_pkg::INJ_HEAD:  inject = cell_q[0];
            iale_pkg::INJ_NEXT:  inject = cell_q[1];
            iale_pkg::INJ_KEY:   inject = key;
            iale_pkg::INJ_CARRY: inject = carry_reg;
            default:             inject = cell_q[0];
        endcase
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        if (k == CAPACITY - 1)
        begin : g_tail
            iale_cell #(
                .ELEM_WIDTH (ELEM_WIDTH)
            ) u_cell (
                .clk   (clk),
                .shift (chain_ctrl.shift),
                .d     (inject),
                .q     (cell_q[k])
            );
        end
        else
        begin : g_body
            iale_cell #(
                .ELEM_WIDTH (ELEM_WIDTH)
            ) u_cell (
                .clk   (clk),
                .shift (chain_ctrl.shift),
                .d     (cell_q[k+1]),
                .q     (cell_q[k])
            );
        end
    end

    // Sequencer: step count, compares against the head, result word
    iale_ctrl #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .position    (position),
        .value_in    (value_in),
        .head        (cell_q[0]),
        .second      (cell_q[1]),
        .chain_ctrl  (chain_ctrl),
        .key         (key),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .value_out   (value_out),
        .found_index (found_index),
        .count       (count),
        .is_empty    (is_empty)
    );

endmodule

>>> src/iale_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iale_checker
// Port-level checks for the indexed array list engine, bound to the top.
// ----------------------------------------------------------------------------
module iale_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic [iale_pkg::CMD_W-1:0]        cmd,
    input logic                              busy,
    input logic                              done,
    input logic                              status,
    input logic signed [iale_pkg::VAL_W-1:0] value_out,
    input logic [iale_pkg::FIDX_W-1:0]       found_index,
    input logic [iale_pkg::CNT_W-1:0]        count,
    input logic                              is_empty
);

    // no result word while a walk is in flight
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (value_out == '0) && (found_index == '0))
        else $error("error result carries data");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == iale_pkg::CMD_CLEAR))
            |=> done && !status && (count == '0) && is_empty)
        else $error("clear did not empty the list");

endmodule

bind indexed_array_list_engine iale_checker u_iale_checker (.*);
